// ===== sv/sm3_pkg.sv =====
// SM3 package: types, constants and round helper functions.
`default_nettype none
package sm3_pkg;
  localparam logic [31:0] T_LOW  = 32'h79cc4519;
  localparam logic [31:0] T_HIGH = 32'h7a879d8a;
  localparam logic [255:0] IV =
    256'h7380166f4914b2b9172442d7da8a0600a96f30bc163138aae38dee4db0fb0e4e;
  localparam logic [31:0] PAD_WORD = 32'h80000000;

  // Datapath commands, written each cycle by the controller.
  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_LOAD  = 3'd1,  // shift a word into the schedule window
    CMD_START = 3'd2,  // copy chaining value into working registers
    CMD_ROUND = 3'd3,  // one compression round
    CMD_FOLD  = 3'd4,  // xor working registers into chaining value
    CMD_INIT  = 3'd5   // reload initial value
  } dp_cmd_t;

  typedef struct packed {
    dp_cmd_t     cmd;
    logic [31:0] load_word;
    logic [5:0]  round;
    logic [2:0]  out_sel;
  } dp_ctrl_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] k);
    logic [63:0] d;
    d = {x, x} << k;
    return d[63:32];
  endfunction

  function automatic logic [31:0] perm0(input logic [31:0] x);
    return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
  endfunction

  function automatic logic [31:0] perm1(input logic [31:0] x);
    return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
  endfunction
endpackage
`default_nettype wire

// ===== sv/sm3_stream_if.sv =====
// Valid/ready stream interface with a generic payload.
`default_nettype none
interface sm3_stream_if #(parameter int Width = 36);
  logic             valid;
  logic             ready;
  logic [Width-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/sm3_datapath.sv =====
// SM3 datapath: 16-word schedule window, working registers, chaining value.
`default_nettype none
module sm3_datapath import sm3_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire dp_ctrl_t ctrl,
  output logic [31:0]   chain_word
);
  logic [31:0] win [16];
  logic [31:0] cv  [8];
  logic [31:0] a, b, c, d, e, f, g, h;
  logic [31:0] w_new, wj, wpj, tj, a12, ss1, ss2, ff, gg, tt1, tt2;
  logic        early;

  assign early = (ctrl.round < 6'd16);
  assign wj    = win[0];
  assign wpj   = win[0] ^ win[4];
  // Expansion for word j+16 from the current window.
  assign w_new = perm1(win[0] ^ win[7] ^ rotl(win[13], 5'd15))
                 ^ rotl(win[3], 5'd7) ^ win[10];
  assign tj    = early ? T_LOW : T_HIGH;
  assign a12   = rotl(a, 5'd12);
  assign ss1   = rotl(a12 + e + rotl(tj, ctrl.round[4:0]), 5'd7);
  assign ss2   = ss1 ^ a12;
  assign ff    = early ? (a ^ b ^ c) : ((a & b) | (a & c) | (b & c));
  assign gg    = early ? (e ^ f ^ g) : ((e & f) | (~e & g));
  assign tt1   = ff + d + ss2 + wpj;
  assign tt2   = gg + h + ss1 + wj;
  assign chain_word = cv[ctrl.out_sel];

  always_ff @(posedge clk) begin
    case (ctrl.cmd)
      CMD_LOAD: begin
        for (int i = 0; i < 15; i++) win[i] <= win[i+1];
        win[15] <= ctrl.load_word;
      end
      CMD_START: begin
        a <= cv[0]; b <= cv[1]; c <= cv[2]; d <= cv[3];
        e <= cv[4]; f <= cv[5]; g <= cv[6]; h <= cv[7];
      end
      CMD_ROUND: begin
        for (int i = 0; i < 15; i++) win[i] <= win[i+1];
        win[15] <= w_new;
        d <= c; c <= rotl(b, 5'd9); b <= a; a <= tt1;
        h <= g; g <= rotl(f, 5'd19); f <= e; e <= perm0(tt2);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.cmd == CMD_INIT) begin
      for (int i = 0; i < 8; i++) cv[i] <= IV[255-32*i -: 32];
    end else if (ctrl.cmd == CMD_FOLD) begin
      cv[0] <= cv[0] ^ a; cv[1] <= cv[1] ^ b; cv[2] <= cv[2] ^ c; cv[3] <= cv[3] ^ d;
      cv[4] <= cv[4] ^ e; cv[5] <= cv[5] ^ f; cv[6] <= cv[6] ^ g; cv[7] <= cv[7] ^ h;
    end
  end
endmodule
`default_nettype wire

// ===== sv/sm3_control.sv =====
// SM3 controller: word intake, padding, round sequencing and digest output.
`default_nettype none
module sm3_control import sm3_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire logic [31:0] in_word,
  input  wire logic [2:0]  in_count,
  input  wire logic     in_last,
  output logic          out_valid,
  input  wire logic     out_ready,
  output logic [2:0]    out_index,
  output dp_ctrl_t      ctrl
);
  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_PAD   = 6'b000010,
    ST_START = 6'b000100,
    ST_ROUND = 6'b001000,
    ST_FOLD  = 6'b010000,
    ST_OUT   = 6'b100000
  } state_t;

  state_t      state, state_next;
  logic [3:0]  word_position;
  logic [63:0] message_length;
  logic [5:0]  round;
  logic        padding;      // message closed, padding words being fed
  logic        pad_extra;    // a full last word still owes the 0x80 word
  logic        len_hi_done;  // high length word already loaded
  logic [2:0]  out_sel;
  logic [2:0]  cnt;
  logic [31:0] keep, mark, short_word, in_load, pad_load;
  logic [63:0] len_sum;
  logic        take;

  assign cnt  = (in_count > 3'd4) ? 3'd4 : in_count;
  assign keep = (cnt == 3'd0) ? 32'd0 : ~(32'hffffffff >> {cnt[1:0], 3'b000});
  assign mark = 32'h80000000 >> {cnt[1:0], 3'b000};
  assign short_word = (in_word & keep) | mark;
  assign in_ready = (state == ST_IDLE);
  assign take = in_valid && in_ready;
  assign len_sum = message_length + {58'd0, (in_last ? cnt : 3'd4), 3'b000};
  assign in_load = (!in_last || cnt == 3'd4) ? in_word : short_word;

  // Padding stream: 0x80 word if owed, zeros, then the two length words.
  always_comb begin
    if (pad_extra) pad_load = PAD_WORD;
    else if (word_position == 4'd14) pad_load = message_length[63:32];
    else if (word_position == 4'd15 && len_hi_done) pad_load = message_length[31:0];
    else pad_load = 32'd0;
  end

  assign out_valid = (state == ST_OUT);
  assign out_index = out_sel;

  always_comb begin
    state_next = state;
    ctrl.cmd = CMD_NONE;
    ctrl.load_word = in_load;
    ctrl.round = round;
    ctrl.out_sel = out_sel;
    case (state)
      ST_IDLE: if (take) begin
        ctrl.cmd = CMD_LOAD;
        if (word_position == 4'd15) state_next = ST_START;
        else if (in_last) state_next = ST_PAD;
      end
      ST_PAD: begin
        ctrl.cmd = CMD_LOAD;
        ctrl.load_word = pad_load;
        if (word_position == 4'd15) state_next = ST_START;
      end
      ST_START: begin ctrl.cmd = CMD_START; state_next = ST_ROUND; end
      ST_ROUND: begin
        ctrl.cmd = CMD_ROUND;
        if (round == 6'd63) state_next = ST_FOLD;
      end
      ST_FOLD: begin
        ctrl.cmd = CMD_FOLD;
        if (!padding) state_next = ST_IDLE;
        else if (len_hi_done) state_next = ST_OUT;
        else state_next = ST_PAD;
      end
      ST_OUT: if (out_ready && out_sel == 3'd7) begin
        ctrl.cmd = CMD_INIT;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      word_position <= 4'd0;
      message_length <= 64'd0;
      round <= 6'd0;
      padding <= 1'b0;
      pad_extra <= 1'b0;
      len_hi_done <= 1'b0;
      out_sel <= 3'd0;
    end else begin
      state <= state_next;
      if (ctrl.cmd == CMD_LOAD) word_position <= word_position + 4'd1;
      if (state == ST_IDLE && take) begin
        message_length <= len_sum;
        if (in_last) begin
          padding <= 1'b1;
          pad_extra <= (cnt == 3'd4);
        end
      end
      if (state == ST_PAD) begin
        if (pad_extra) pad_extra <= 1'b0;
        else if (word_position == 4'd14) len_hi_done <= 1'b1;
      end
      if (state == ST_ROUND) round <= round + 6'd1;
      if (state == ST_OUT && out_ready) begin
        out_sel <= out_sel + 3'd1;
        if (out_sel == 3'd7) begin
          padding <= 1'b0;
          len_hi_done <= 1'b0;
          message_length <= 64'd0;
          word_position <= 4'd0;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== sv/sm3_hash_unit.sv =====
// SM3 hash unit top level: controller plus datapath behind stream ports.
// Sequencing: a word that fills a block is followed by its compression (load, start,
// 64 rounds, fold); other words are taken directly. A last word adds padding loads and one
// or two compressions, then eight digest transactions, one per cycle while out_ready is high.
// Each 16-word block is compressed (start, 64 rounds, fold) on the single shared round unit,
// and no new word is taken until the fold is done.
// Reset: synchronous active-high rst loads the SM3 initial value, clears counts.
`default_nettype none
module sm3_hash_unit import sm3_pkg::*; (
  input wire logic    clk,
  input wire logic    rst,
  sm3_stream_if.sink   in_msg,
  sm3_stream_if.source out_digest
);
  dp_ctrl_t    ctrl;
  logic [31:0] chain_word;
  logic [2:0]  out_index;
  logic        out_valid;

  // Payload order: message_word, byte_count, last_word.
  sm3_control u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_msg.valid),
    .in_ready  (in_msg.ready),
    .in_word   (in_msg.data[35:4]),
    .in_count  (in_msg.data[3:1]),
    .in_last   (in_msg.data[0]),
    .out_valid (out_valid),
    .out_ready (out_digest.ready),
    .out_index (out_index),
    .ctrl      (ctrl)
  );

  sm3_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .chain_word (chain_word)
  );

  // Digest words read straight from the held chaining value.
  assign out_digest.valid = out_valid;
  assign out_digest.data  = {chain_word, out_index, (out_index == 3'd7)};
endmodule
`default_nettype wire
